### rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and defaults for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 6;

  localparam logic [15:0] INTERVAL_RST = 16'd5000;
  localparam logic [7:0]  SLACK_RST    = 8'd8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK    = 1'd1;

  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_ALIGNED = 3'd1;
  localparam logic [2:0] MODE_FREE    = 3'd2;
  localparam logic [2:0] MODE_COLLECT = 3'd3;
  localparam logic [2:0] MODE_CHECK   = 3'd4;
  localparam logic [2:0] MODE_WALK    = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_BADALIGN = 3'd2;
  localparam logic [2:0] ST_SKIPPED  = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  localparam int STAT_W = 13;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] size;
    logic [15:0] alignment;
    logic [11:0] address;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [11:0]       result_address;
    logic [STAT_W-1:0] recovered_bytes;
    logic [STAT_W-1:0] used_bytes;
    logic [STAT_W-1:0] peak_bytes;
    logic [15:0]       alloc_count;
    logic [STAT_W-1:0] avail_bytes;
    logic [STAT_W-1:0] free_list_bytes;
  } out_item_t;

endpackage

### rtl/core/ffha_stream_if.sv
// ----------------------------------------------------------------------------
// ffha_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ffha_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a linked free list of block headers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request beat (mode, size, alignment, address, now_ms);
//   out_ch returns exactly one result beat per request, in order.
//   cfg_we/cfg_idx/cfg_wdata write collect_interval_ms (index 0) and
//   split_slack_bytes (index 1); write only while no request is in flight.
// Flow:
//   Headers sit in a single-port-write, registered-read memory, so every
//   free-list link is visited in a read state and then an evaluate state.
//   A fitting alloc writes the split-off header, then the block header
//   (both only when the block splits), then relinks its predecessor;
//   collect merges neighbours in a check/merge loop. Bad requests go
//   straight to the done state. One request is worked on at a time; the
//   next beat is accepted as soon as the result is in the output register.
// Reset:
//   The whole heap is one free block at offset zero, statistics are zero,
//   registers take their defaults. No clearing pass is needed.
// Stall:
//   A result waits in the output register until out_ch.ready; a finished
//   request behind it holds until the register drains.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ffha_stream_if.sink                      in_ch,
  ffha_stream_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ffha_pkg::*;

  localparam int AW  = $clog2(HEAP_BYTES);
  localparam int SZW = $clog2(HEAP_BYTES + 1);
  localparam int ACW = SZW + 2;
  localparam int SW  = $clog2(HEAP_BYTES + 1);
  localparam int HW  = SZW + AW + 1;
  localparam int RW  = 18;
  localparam logic [SZW-1:0] HDR_SZ  = SZW'(HEADER_BYTES);
  localparam logic [ACW-1:0] HDR_AC  = ACW'(HEADER_BYTES);
  localparam logic [ACW-1:0] HEAP_AC = ACW'(HEAP_BYTES);
  localparam logic [RW-1:0]  HEAP_RW = RW'(HEAP_BYTES);
  localparam logic [SW-1:0]  LIMIT   = SW'(HEAP_BYTES);
  localparam logic [HW-1:0]  RST_HDR =
    {SZW'(HEAP_BYTES - HEADER_BYTES), {AW{1'b0}}, 1'b0};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_WP   = 3'd4;
  localparam logic [2:0] S_CCHK = 3'd5;
  localparam logic [2:0] S_CNX  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  function automatic logic [ACW-1:0] sat_heap(input logic [ACW-1:0] v);
    sat_heap = (v > HEAP_AC) ? HEAP_AC : v;
  endfunction

  logic [2:0]     state_r, state_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic [15:0]    align_r, align_nxt;
  logic [AW-1:0]  p_r, p_nxt, prev_r, prev_nxt, lnk_r, lnk_nxt;
  logic           lnkv_r, lnkv_nxt, have_prev_r, have_prev_nxt, split_r, split_nxt;
  logic [SZW-1:0] prev_size_r, prev_size_nxt, need_r, need_nxt, nb_size_r, nb_size_nxt;
  logic [SW-1:0]  steps_r, steps_nxt;
  logic [SZW-1:0] cur_size_r, cur_size_nxt;
  logic [AW-1:0]  cur_next_r, cur_next_nxt;
  logic           cur_nv_r, cur_nv_nxt;
  logic [ACW-1:0] acc_r, acc_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [11:0]    raddr_r, raddr_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic           head_v_r, head_v_nxt;
  logic [SZW-1:0] total_r, total_nxt, peak_r, peak_nxt;
  logic [15:0]    cnt_r, cnt_nxt;
  logic [31:0]    last_ms_r, last_ms_nxt;
  logic [15:0]    ival_r;
  logic [7:0]     slack_r;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [HW-1:0]  mem_wdata, mem_rdata;
  logic [SZW-1:0] rd_size;
  logic [AW-1:0]  rd_next;
  logic           rd_nv;

  assign rd_size = mem_rdata[HW-1 -: SZW];
  assign rd_next = mem_rdata[AW:1];
  assign rd_nv   = mem_rdata[0];

  ffha_hdr_mem #(
    .DEPTH(HEAP_BYTES), .AW(AW), .DW(HW), .RST_WORD(RST_HDR)
  ) u_hdr_mem (
    .clk(clk), .rst_n(rst_n), .we(mem_we), .waddr(mem_waddr),
    .wdata(mem_wdata), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign mem_raddr = (state_r == S_CCHK) ? cur_next_r : p_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    logic [RW-1:0]  req, needw, pay, algm;
    logic [SZW-1:0] remain, psz;
    logic [ACW-1:0] nb, sum, chk, tot;
    logic [SW-1:0]  s1;
    logic           split;

    state_nxt = state_r; mode_nxt = mode_r; align_nxt = align_r;
    p_nxt = p_r; prev_nxt = prev_r; lnk_nxt = lnk_r; lnkv_nxt = lnkv_r;
    have_prev_nxt = have_prev_r; split_nxt = split_r;
    prev_size_nxt = prev_size_r; need_nxt = need_r; nb_size_nxt = nb_size_r;
    steps_nxt = steps_r;
    cur_size_nxt = cur_size_r; cur_next_nxt = cur_next_r; cur_nv_nxt = cur_nv_r;
    acc_nxt = acc_r; status_nxt = status_r; raddr_nxt = raddr_r;
    head_nxt = head_r; head_v_nxt = head_v_r;
    total_nxt = total_r; peak_nxt = peak_r; cnt_nxt = cnt_r; last_ms_nxt = last_ms_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    mem_we = 1'b0; mem_waddr = p_r; mem_wdata = '0;
    req = '0; needw = '0; pay = '0; algm = '0;
    remain = '0; psz = '0; nb = '0; sum = '0; chk = '0; tot = '0;
    s1 = steps_r + SW'(1); split = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.data.mode;
          align_nxt = in_ch.data.alignment;
          status_nxt = ST_OK; raddr_nxt = '0; acc_nxt = '0;
          steps_nxt = '0; have_prev_nxt = 1'b0;
          p_nxt = head_r;
          state_nxt = S_DONE;
          case (in_ch.data.mode)
            MODE_ALLOC, MODE_ALIGNED: begin
              if (in_ch.data.mode == MODE_ALIGNED) begin
                req = RW'(in_ch.data.size) + RW'(in_ch.data.alignment) - RW'(1);
              end else begin
                req = RW'(in_ch.data.size);
              end
              needw = (req + RW'(1)) & ~RW'(1);
              if (in_ch.data.mode == MODE_ALIGNED && (in_ch.data.alignment == '0 ||
                  (in_ch.data.alignment & (in_ch.data.alignment - 16'd1)) != '0)) begin
                status_nxt = ST_BADALIGN;
              end else if (req == '0 || req > HEAP_RW || needw > HEAP_RW || !head_v_r) begin
                status_nxt = ST_NOFIT;
              end else begin
                need_nxt = SZW'(needw);
                state_nxt = S_RD;
              end
            end
            MODE_FREE: begin
              if (32'(in_ch.data.address) >= 32'(HEADER_BYTES) &&
                  32'(in_ch.data.address) < 32'(HEAP_BYTES)) begin
                p_nxt = AW'(32'(in_ch.data.address) - 32'(HEADER_BYTES));
                state_nxt = S_RD;
              end
            end
            MODE_COLLECT: begin
              if (in_ch.data.now_ms - last_ms_r < 32'(ival_r)) begin
                status_nxt = ST_SKIPPED;
              end else begin
                last_ms_nxt = in_ch.data.now_ms;
                if (head_v_r) state_nxt = S_RD;
              end
            end
            MODE_CHECK, MODE_WALK: begin
              if (head_v_r) state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_RD: state_nxt = S_EV;

      S_EV: begin
        case (mode_r)
          MODE_ALLOC, MODE_ALIGNED: begin
            if (rd_size >= need_r) begin
              remain = rd_size - need_r;
              nb = ACW'(p_r) + HDR_AC + ACW'(need_r);
              split = (ACW'(remain) > HDR_AC + ACW'(slack_r)) && (nb < HEAP_AC);
              split_nxt = split;
              if (split) begin
                nb_size_nxt = remain - HDR_SZ;
                mem_we = 1'b1;
                mem_waddr = AW'(nb);
                mem_wdata = {remain - HDR_SZ, rd_next, rd_nv};
                lnk_nxt = AW'(nb); lnkv_nxt = 1'b1;
                state_nxt = S_WB;
              end else begin
                lnk_nxt = rd_next; lnkv_nxt = rd_nv;
                state_nxt = S_WP;
              end
            end else begin
              prev_nxt = p_r; prev_size_nxt = rd_size; have_prev_nxt = 1'b1;
              steps_nxt = s1;
              if (!rd_nv || s1 == LIMIT || 32'(rd_next) >= 32'(HEAP_BYTES)) begin
                status_nxt = ST_NOFIT;
                state_nxt = S_DONE;
              end else begin
                p_nxt = rd_next;
                state_nxt = S_RD;
              end
            end
          end
          MODE_FREE: begin
            sum = ACW'(rd_size) + HDR_AC;
            total_nxt = (ACW'(total_r) > sum) ? SZW'(ACW'(total_r) - sum) : '0;
            mem_we = 1'b1;
            mem_waddr = p_r;
            mem_wdata = {rd_size, head_r, head_v_r};
            head_nxt = p_r; head_v_nxt = 1'b1;
            state_nxt = S_DONE;
          end
          MODE_COLLECT: begin
            cur_size_nxt = rd_size; cur_next_nxt = rd_next; cur_nv_nxt = rd_nv;
            state_nxt = S_CCHK;
          end
          MODE_CHECK: begin
            chk = acc_r + ACW'(rd_size) + HDR_AC;
            state_nxt = S_DONE;
            if (rd_size == '0 || ACW'(rd_size) > HEAP_AC || chk > HEAP_AC) begin
              status_nxt = ST_CORRUPT;
            end else begin
              acc_nxt = chk;
              steps_nxt = s1;
              if (rd_nv && s1 != LIMIT) begin
                if (32'(rd_next) >= 32'(HEAP_BYTES)) begin
                  status_nxt = ST_CORRUPT;
                end else begin
                  p_nxt = rd_next;
                  state_nxt = S_RD;
                end
              end
            end
          end
          default: begin
            // free-space walk
            acc_nxt = sat_heap(acc_r + ACW'(rd_size));
            steps_nxt = s1;
            state_nxt = S_DONE;
            if (rd_nv && s1 != LIMIT && 32'(rd_next) < 32'(HEAP_BYTES)) begin
              p_nxt = rd_next;
              state_nxt = S_RD;
            end
          end
        endcase
      end

      S_WB: begin
        mem_we = 1'b1;
        mem_waddr = p_r;
        mem_wdata = {need_r, lnk_r, lnkv_r};
        state_nxt = S_WP;
      end

      S_WP: begin
        // prev may alias a header rewritten earlier in this request
        if (split_r && prev_r == lnk_r) begin
          psz = nb_size_r;
        end else if (prev_r == p_r) begin
          psz = need_r;
        end else begin
          psz = prev_size_r;
        end
        if (have_prev_r) begin
          mem_we = 1'b1;
          mem_waddr = prev_r;
          mem_wdata = {psz, lnk_r, lnkv_r};
        end else begin
          head_nxt = lnk_r; head_v_nxt = lnkv_r;
        end
        tot = sat_heap(ACW'(total_r) + ACW'(need_r) + HDR_AC);
        total_nxt = SZW'(tot);
        if (SZW'(tot) > peak_r) peak_nxt = SZW'(tot);
        cnt_nxt = cnt_r + 16'd1;
        pay = RW'(p_r) + RW'(HEADER_BYTES);
        if (mode_r == MODE_ALIGNED) begin
          algm = RW'(align_r) - RW'(1);
          raddr_nxt = 12'((pay + algm) & ~algm);
        end else begin
          raddr_nxt = 12'(pay);
        end
        state_nxt = S_DONE;
      end

      S_CCHK: begin
        if (steps_r == LIMIT || !cur_nv_r || 32'(cur_next_r) >= 32'(HEAP_BYTES)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CNX;
        end
      end

      S_CNX: begin
        steps_nxt = s1;
        if (ACW'(p_r) + HDR_AC + ACW'(cur_size_r) == ACW'(cur_next_r)) begin
          sum = sat_heap(ACW'(cur_size_r) + HDR_AC + ACW'(rd_size));
          cur_size_nxt = SZW'(sum); cur_next_nxt = rd_next; cur_nv_nxt = rd_nv;
          mem_we = 1'b1;
          mem_waddr = p_r;
          mem_wdata = {SZW'(sum), rd_next, rd_nv};
          acc_nxt = sat_heap(acc_r + HDR_AC);
        end else begin
          p_nxt = cur_next_r;
          cur_size_nxt = rd_size; cur_next_nxt = rd_next; cur_nv_nxt = rd_nv;
        end
        state_nxt = S_CCHK;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status          = status_r;
          out_data_nxt.result_address  = raddr_r;
          out_data_nxt.recovered_bytes = (mode_r == MODE_COLLECT) ? STAT_W'(acc_r) : '0;
          out_data_nxt.used_bytes      = STAT_W'(total_r);
          out_data_nxt.peak_bytes      = STAT_W'(peak_r);
          out_data_nxt.alloc_count     = cnt_r;
          out_data_nxt.avail_bytes     = STAT_W'(32'(HEAP_BYTES) - 32'(total_r));
          out_data_nxt.free_list_bytes = (mode_r == MODE_WALK) ? STAT_W'(acc_r) : '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      head_v_r    <= 1'b1;
      total_r     <= '0;
      peak_r      <= '0;
      cnt_r       <= '0;
      last_ms_r   <= '0;
      out_valid_r <= 1'b0;
      ival_r      <= INTERVAL_RST;
      slack_r     <= SLACK_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      head_v_r    <= head_v_nxt;
      total_r     <= total_nxt;
      peak_r      <= peak_nxt;
      cnt_r       <= cnt_nxt;
      last_ms_r   <= last_ms_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == REG_INTERVAL) ival_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_SLACK) slack_r <= cfg_wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; align_r <= align_nxt;
    p_r <= p_nxt; prev_r <= prev_nxt; lnk_r <= lnk_nxt; lnkv_r <= lnkv_nxt;
    have_prev_r <= have_prev_nxt; split_r <= split_nxt;
    prev_size_r <= prev_size_nxt; need_r <= need_nxt; nb_size_r <= nb_size_nxt;
    steps_r <= steps_nxt;
    cur_size_r <= cur_size_nxt; cur_next_r <= cur_next_nxt; cur_nv_r <= cur_nv_nxt;
    acc_r <= acc_nxt; status_r <= status_nxt; raddr_r <= raddr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(HEAP_BYTES))
    else $error("allocated total above heap size");

  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= total_r)
    else $error("peak below allocated total");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == S_IDLE || state_r == S_DONE) && mem_we))
    else $error("header write outside an operation");

endmodule

### rtl/core/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one write and one registered read per cycle. Entry zero
// reads as its reset word until first written.
// ----------------------------------------------------------------------------
module ffha_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 26,
  parameter logic [DW-1:0] RST_WORD = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr_r;
  logic          e0_written_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
    rd_addr_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_written_r <= 1'b0;
    end else if (we && waddr == '0) begin
      e0_written_r <= 1'b1;
    end
  end

  assign rdata = (rd_addr_r == '0 && !e0_written_r) ? RST_WORD : rd_data_r;

endmodule
